// ----- design/ctm_pkg.sv -----
package ctm_pkg;

    localparam int POOL_NODES = 256;
    localparam int TYPE_COUNT = 16;
    localparam int SLOTS = 4;
    localparam int CHAIN_MAX = (TYPE_COUNT + SLOTS - 1) / SLOTS;
    localparam int BUF_SLOTS = (CHAIN_MAX + 1) * SLOTS;
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int LINK_W = NODE_W + 1;
    localparam int SLOT_AW = $clog2(POOL_NODES * SLOTS);
    localparam int J_W = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int BUF_W = $clog2(BUF_SLOTS + 1);
    localparam int NN_W = $clog2(CHAIN_MAX + 2);
    localparam int TYPE_W = 4;
    localparam int VAL_W = 32;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_DEALLOC = 2'd1,
        CMD_SET     = 2'd2,
        CMD_FETCH   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                command;
        logic [NODE_W-1:0]   obj_index;
        logic [TYPE_W-1:0]   entry_type;
        logic [VAL_W-1:0]    entry_value;
        logic [TYPE_COUNT-1:0] type_mask;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] result_index;
        logic [TYPE_W-1:0] result_type;
        logic [VAL_W-1:0]  result_value;
        status_t           status;
        logic              last;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_TAKE, OP_POP, OP_AINIT, OP_DRD, OP_DWR, OP_WRD, OP_WSL,
        OP_SRCH, OP_SVAL, OP_LPREV, OP_LNEW, OP_SINS, OP_SDEL, OP_WB, OP_TRIM,
        OP_PUSH, OP_FETCH, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t emit_st;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic bad_idx;
        logic can_alloc;
        logic use_free;
        logic chain_end;
        logic slot_last;
        logic hit;
        logic val_zero;
        logic grow;
        logic wb_done;
        logic trim;
        logic push_done;
        logic fetch_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- design/ctm_ctrl.sv -----
module ctm_ctrl import ctm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  dcmd
);

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_DEC   = 21'h000002,
        S_TAKE  = 21'h000004,
        S_POP   = 21'h000008,
        S_AINIT = 21'h000010,
        S_DRD   = 21'h000020,
        S_DWR   = 21'h000040,
        S_WRD   = 21'h000080,
        S_WSL   = 21'h000100,
        S_SRCH  = 21'h000200,
        S_SDEC  = 21'h000400,
        S_SVAL  = 21'h000800,
        S_LPREV = 21'h001000,
        S_LNEW  = 21'h002000,
        S_SINS  = 21'h004000,
        S_SDEL  = 21'h008000,
        S_WB    = 21'h010000,
        S_TRIM  = 21'h020000,
        S_PUSH  = 21'h040000,
        S_FETCH = 21'h080000,
        S_EMIT  = 21'h100000
    } state_t;

    state_t  state_reg, state_next;
    status_t est_reg, est_next;
    state_t  after_take;

    assign s_ready = (state_reg == S_IDLE);
    assign after_take = (stat.cmd == CMD_ALLOC) ? S_AINIT : S_LPREV;

    always_comb begin
        state_next = state_reg;
        est_next = est_reg;
        dcmd.op = OP_NONE;
        dcmd.emit_st = est_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    dcmd.op = OP_LOAD;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                est_next = ST_OK;
                if (stat.cmd == CMD_ALLOC) begin
                    if (stat.can_alloc) begin
                        state_next = S_TAKE;
                    end else begin
                        est_next = ST_FULL;
                        state_next = S_EMIT;
                    end
                end else if (stat.bad_idx) begin
                    est_next = ST_BAD;
                    state_next = S_EMIT;
                end else if (stat.cmd == CMD_DEALLOC) begin
                    state_next = S_DRD;
                end else begin
                    state_next = S_WRD;
                end
            end
            S_TAKE: begin
                dcmd.op = OP_TAKE;
                state_next = stat.use_free ? S_POP : after_take;
            end
            S_POP: begin
                dcmd.op = OP_POP;
                state_next = after_take;
            end
            S_AINIT: begin
                dcmd.op = OP_AINIT;
                state_next = S_EMIT;
            end
            S_DRD: begin
                dcmd.op = OP_DRD;
                state_next = S_DWR;
            end
            S_DWR: begin
                dcmd.op = OP_DWR;
                state_next = stat.chain_end ? S_EMIT : S_DRD;
            end
            S_WRD: begin
                dcmd.op = OP_WRD;
                state_next = S_WSL;
            end
            S_WSL: begin
                dcmd.op = OP_WSL;
                if (stat.slot_last) begin
                    if (!stat.chain_end) begin
                        state_next = S_WRD;
                    end else if (stat.cmd == CMD_FETCH) begin
                        state_next = S_FETCH;
                    end else begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                dcmd.op = OP_SRCH;
                state_next = S_SDEC;
            end
            S_SDEC: begin
                if (!stat.val_zero) begin
                    if (stat.hit) begin
                        state_next = S_SVAL;
                    end else if (!stat.grow) begin
                        state_next = S_SINS;
                    end else if (stat.can_alloc) begin
                        state_next = S_TAKE;
                    end else begin
                        est_next = ST_FULL;
                        state_next = S_EMIT;
                    end
                end else begin
                    state_next = stat.hit ? S_SDEL : S_EMIT;
                end
            end
            S_SVAL: begin
                dcmd.op = OP_SVAL;
                state_next = S_WB;
            end
            S_LPREV: begin
                dcmd.op = OP_LPREV;
                state_next = S_LNEW;
            end
            S_LNEW: begin
                dcmd.op = OP_LNEW;
                state_next = S_SINS;
            end
            S_SINS: begin
                dcmd.op = OP_SINS;
                state_next = S_WB;
            end
            S_SDEL: begin
                dcmd.op = OP_SDEL;
                state_next = S_WB;
            end
            S_WB: begin
                dcmd.op = OP_WB;
                if (stat.wb_done) begin
                    state_next = stat.trim ? S_TRIM : S_EMIT;
                end
            end
            S_TRIM: begin
                dcmd.op = OP_TRIM;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                dcmd.op = OP_PUSH;
                if (stat.push_done) begin
                    state_next = S_EMIT;
                end
            end
            S_FETCH: begin
                dcmd.op = OP_FETCH;
                if (stat.fetch_done) begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                dcmd.op = OP_EMIT;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            est_reg <= ST_OK;
        end else begin
            state_reg <= state_next;
            est_reg <= est_next;
        end
    end

    // a result word only leaves from the emit or fetch states
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcmd.op == OP_EMIT || dcmd.op == OP_FETCH) |->
        (state_reg == S_EMIT || state_reg == S_FETCH))
        else $error("result op outside emit/fetch");

    a_new_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DEC))
        else $error("accepted word not decoded");

    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("emit did not finish");

endmodule

// ----- design/ctm_datapath.sv -----
module ctm_datapath import ctm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_item,
    input  dp_cmd_t   dcmd,
    output dp_stat_t  stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    in_item_t item_reg;
    logic [LINK_W-1:0] free_head_reg, fresh_reg;
    logic [NODE_W-1:0] cur_reg, tkn_reg;
    logic [NODE_W-1:0] nodes_reg [CHAIN_MAX+1];
    logic [NN_W-1:0] nn_reg;
    logic [BUF_W-1:0] n_reg, cnt_reg, pos_reg;
    logic hit_reg;
    logic [TYPE_W-1:0] buf_ty_reg [BUF_SLOTS];
    logic [VAL_W-1:0] buf_va_reg [BUF_SLOTS];
    logic out_valid_reg;
    out_item_t out_reg;

    logic [LINK_W-1:0] link_mem [POOL_NODES];
    logic [FILL_W-1:0] fill_mem [POOL_NODES];
    logic [TYPE_W+VAL_W-1:0] slot_mem [POOL_NODES*SLOTS];
    logic [LINK_W-1:0] link_q;
    logic [FILL_W-1:0] fill_q;
    logic [TYPE_W+VAL_W-1:0] slot_q;

    logic out_free, use_free, chain_end;
    logic [FILL_W-1:0] fill_c;
    logic [NN_W-1:0] need, grow_need;
    logic [NN_W-1:0] wb_k;
    logic [J_W-1:0] wb_j;
    logic signed [BUF_W+2:0] fk_s;
    logic [FILL_W-1:0] fk;
    logic wb_act;
    logic [NN_W-1:0] node_sel;
    logic [NODE_W-1:0] node_rd;
    logic s_hit, s_done;
    logic [BUF_W-1:0] s_pos;
    logic [TYPE_W-1:0] f_t;
    logic [VAL_W-1:0] f_val;
    logic f_done, f_sel, f_adv, f_last;
    logic link_re, link_we;
    logic [NODE_W-1:0] link_ra, link_wa;
    logic [LINK_W-1:0] link_wd;
    logic fill_we;
    logic [NODE_W-1:0] fill_wa;
    logic [FILL_W-1:0] fill_wd;
    logic slot_re, slot_we;
    logic [J_W-1:0] slot_rj;

    assign out_free = !out_valid_reg || m_ready;
    assign use_free = free_head_reg < fresh_reg;
    assign chain_end = (link_q >= fresh_reg) || (nn_reg == NN_W'(CHAIN_MAX - 1));
    assign fill_c = (fill_q > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : fill_q;
    assign need = (n_reg == '0) ? NN_W'(1) : NN_W'((n_reg + BUF_W'(SLOTS - 1)) >> J_W);
    assign grow_need = NN_W'(n_reg >> J_W) + NN_W'(1);
    assign wb_k = NN_W'(cnt_reg >> J_W);
    assign wb_j = cnt_reg[J_W-1:0];
    assign fk_s = $signed({3'b000, n_reg}) - $signed({3'b000, cnt_reg} & ~(BUF_W+3)'(SLOTS-1));
    assign fk = (fk_s < 0) ? '0 : (fk_s > SLOTS) ? FILL_W'(SLOTS) : FILL_W'(fk_s);
    assign wb_act = (dcmd.op == OP_WB) && (wb_k < need) && (wb_k < nn_reg);

    always_comb begin
        case (dcmd.op)
            OP_LPREV: node_sel = nn_reg - NN_W'(1);
            OP_WB:    node_sel = wb_k;
            OP_TRIM:  node_sel = need - NN_W'(1);
            OP_PUSH:  node_sel = NN_W'(cnt_reg);
            default:  node_sel = '0;
        endcase
    end
    assign node_rd = (node_sel <= NN_W'(CHAIN_MAX)) ? nodes_reg[node_sel] : '0;

    // find the entry, or where it would go
    always_comb begin
        s_hit = 1'b0;
        s_done = 1'b0;
        s_pos = n_reg;
        for (int i = 0; i < BUF_SLOTS; i++) begin
            if (!s_done && BUF_W'(i) < n_reg) begin
                if (buf_ty_reg[i] == item_reg.entry_type) begin
                    s_hit = 1'b1;
                    s_pos = BUF_W'(i);
                    s_done = 1'b1;
                end else if (buf_ty_reg[i] > item_reg.entry_type) begin
                    s_pos = BUF_W'(i);
                    s_done = 1'b1;
                end
            end
        end
    end

    assign f_t = cnt_reg[TYPE_W-1:0];
    always_comb begin
        f_val = '0;
        f_done = 1'b0;
        for (int i = 0; i < BUF_SLOTS; i++) begin
            if (!f_done && BUF_W'(i) < n_reg && buf_ty_reg[i] == f_t) begin
                f_val = buf_va_reg[i];
                f_done = 1'b1;
            end
        end
    end
    assign f_sel = item_reg.type_mask[f_t];
    assign f_adv = (dcmd.op == OP_FETCH) && (!f_sel || out_free);
    assign f_last = ((item_reg.type_mask >> f_t) >> 1) == '0;

    // memory port selection
    always_comb begin
        link_re = 1'b0;
        link_ra = cur_reg;
        link_we = 1'b0;
        link_wa = tkn_reg;
        link_wd = NULL_LINK;
        fill_we = 1'b0;
        fill_wa = tkn_reg;
        fill_wd = '0;
        slot_re = 1'b0;
        slot_rj = wb_j + J_W'(1);
        case (dcmd.op)
            OP_TAKE: begin
                link_re = use_free;
                link_ra = free_head_reg[NODE_W-1:0];
            end
            OP_AINIT: begin
                link_we = 1'b1;
                fill_we = 1'b1;
            end
            OP_DRD: begin
                link_re = 1'b1;
            end
            OP_DWR: begin
                link_we = 1'b1;
                link_wa = cur_reg;
                link_wd = free_head_reg;
            end
            OP_WRD: begin
                link_re = 1'b1;
                slot_re = 1'b1;
                slot_rj = '0;
            end
            OP_WSL: begin
                slot_re = 1'b1;
            end
            OP_LPREV: begin
                link_we = 1'b1;
                link_wa = node_rd;
                link_wd = {1'b0, tkn_reg};
            end
            OP_LNEW: begin
                link_we = 1'b1;
            end
            OP_WB: begin
                fill_we = wb_act && (wb_j == '0);
                fill_wa = node_rd;
                fill_wd = fk;
            end
            OP_TRIM: begin
                link_we = 1'b1;
                link_wa = node_rd;
            end
            OP_PUSH: begin
                link_we = 1'b1;
                link_wa = node_rd;
                link_wd = free_head_reg;
            end
            default: begin
            end
        endcase
    end
    assign slot_we = wb_act && ({1'b0, wb_j} < fk);

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_q <= link_mem[link_ra];
            fill_q <= fill_mem[link_ra];
        end
        if (fill_we) begin
            fill_mem[fill_wa] <= fill_wd;
        end
        if (slot_we) begin
            slot_mem[{node_rd, wb_j}] <= {buf_ty_reg[cnt_reg], buf_va_reg[cnt_reg]};
        end
        if (slot_re) begin
            slot_q <= slot_mem[{cur_reg, slot_rj}];
        end
    end

    // chain buffer
    always_ff @(posedge aclk) begin
        case (dcmd.op)
            OP_LOAD: item_reg <= s_item;
            OP_WSL: begin
                if ({1'b0, wb_j} < fill_c) begin
                    for (int i = 0; i < BUF_SLOTS; i++) begin
                        if (BUF_W'(i) == n_reg) begin
                            buf_ty_reg[i] <= slot_q[TYPE_W+VAL_W-1:VAL_W];
                            buf_va_reg[i] <= slot_q[VAL_W-1:0];
                        end
                    end
                end
            end
            OP_SVAL: begin
                for (int i = 0; i < BUF_SLOTS; i++) begin
                    if (BUF_W'(i) == pos_reg) begin
                        buf_va_reg[i] <= item_reg.entry_value;
                    end
                end
            end
            OP_SINS: begin
                for (int i = 0; i < BUF_SLOTS; i++) begin
                    if (BUF_W'(i) == pos_reg) begin
                        buf_ty_reg[i] <= item_reg.entry_type;
                        buf_va_reg[i] <= item_reg.entry_value;
                    end
                end
                for (int i = 1; i < BUF_SLOTS; i++) begin
                    if (BUF_W'(i) > pos_reg && BUF_W'(i) <= n_reg) begin
                        buf_ty_reg[i] <= buf_ty_reg[i-1];
                        buf_va_reg[i] <= buf_va_reg[i-1];
                    end
                end
            end
            OP_SDEL: begin
                for (int i = 0; i < BUF_SLOTS - 1; i++) begin
                    if (BUF_W'(i) >= pos_reg && BUF_W'(i + 1) < n_reg) begin
                        buf_ty_reg[i] <= buf_ty_reg[i+1];
                        buf_va_reg[i] <= buf_va_reg[i+1];
                    end
                end
            end
            OP_LNEW: begin
                for (int i = 0; i <= CHAIN_MAX; i++) begin
                    if (NN_W'(i) == nn_reg) begin
                        nodes_reg[i] <= tkn_reg;
                    end
                end
            end
            default: begin
            end
        endcase
        if (dcmd.op == OP_WSL && wb_j == J_W'(SLOTS - 1)) begin
            for (int i = 0; i <= CHAIN_MAX; i++) begin
                if (NN_W'(i) == nn_reg) begin
                    nodes_reg[i] <= cur_reg;
                end
            end
        end
        if (dcmd.op == OP_SRCH) begin
            pos_reg <= s_pos;
            hit_reg <= s_hit;
        end
        if (dcmd.op == OP_TAKE && !use_free) begin
            tkn_reg <= fresh_reg[NODE_W-1:0];
        end
        if (dcmd.op == OP_POP) begin
            tkn_reg <= free_head_reg[NODE_W-1:0];
        end
        if (dcmd.op == OP_LOAD) begin
            cur_reg <= s_item.obj_index;
        end else if ((dcmd.op == OP_DWR ||
                      (dcmd.op == OP_WSL && wb_j == J_W'(SLOTS - 1))) && !chain_end) begin
            cur_reg <= link_q[NODE_W-1:0];
        end
        if ((dcmd.op == OP_EMIT && out_free) || (f_adv && f_sel)) begin
            out_reg.result_index <= (dcmd.op == OP_EMIT && dcmd.emit_st == ST_OK &&
                                     item_reg.command == CMD_ALLOC) ? tkn_reg : '0;
            out_reg.result_type <= (dcmd.op == OP_FETCH) ? f_t : '0;
            out_reg.result_value <= (dcmd.op == OP_FETCH) ? f_val : '0;
            out_reg.status <= (dcmd.op == OP_FETCH) ? ST_OK : dcmd.emit_st;
            out_reg.last <= (dcmd.op == OP_FETCH) ? f_last : 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= NULL_LINK;
            fresh_reg <= '0;
            nn_reg <= '0;
            n_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((dcmd.op == OP_EMIT && out_free) || (f_adv && f_sel)) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (dcmd.op)
                OP_LOAD: begin
                    nn_reg <= '0;
                    n_reg <= '0;
                    cnt_reg <= '0;
                end
                OP_TAKE: begin
                    if (!use_free) begin
                        fresh_reg <= fresh_reg + LINK_W'(1);
                    end
                end
                OP_POP: begin
                    free_head_reg <= (link_q >= fresh_reg) ? NULL_LINK : link_q;
                end
                OP_DWR: begin
                    free_head_reg <= {1'b0, cur_reg};
                    nn_reg <= nn_reg + NN_W'(1);
                end
                OP_WSL: begin
                    if ({1'b0, wb_j} < fill_c) begin
                        n_reg <= n_reg + BUF_W'(1);
                    end
                    if (wb_j == J_W'(SLOTS - 1)) begin
                        nn_reg <= nn_reg + NN_W'(1);
                        cnt_reg <= '0;
                    end else begin
                        cnt_reg <= cnt_reg + BUF_W'(1);
                    end
                end
                OP_SRCH: cnt_reg <= '0;
                OP_LNEW: nn_reg <= nn_reg + NN_W'(1);
                OP_SINS: n_reg <= n_reg + BUF_W'(1);
                OP_SDEL: n_reg <= n_reg - BUF_W'(1);
                OP_WB: cnt_reg <= cnt_reg + BUF_W'(1);
                OP_TRIM: cnt_reg <= BUF_W'(need);
                OP_PUSH: begin
                    free_head_reg <= {1'b0, node_rd};
                    cnt_reg <= cnt_reg + BUF_W'(1);
                end
                OP_FETCH: begin
                    if (f_adv) begin
                        cnt_reg <= cnt_reg + BUF_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        stat.cmd = item_reg.command;
        stat.bad_idx = {1'b0, item_reg.obj_index} >= fresh_reg;
        stat.can_alloc = use_free || (fresh_reg < LINK_W'(POOL_NODES));
        stat.use_free = use_free;
        stat.chain_end = chain_end;
        stat.slot_last = (wb_j == J_W'(SLOTS - 1));
        stat.hit = hit_reg;
        stat.val_zero = (item_reg.entry_value == '0);
        stat.grow = grow_need > nn_reg;
        stat.wb_done = cnt_reg == (BUF_W'({nn_reg, {J_W{1'b0}}}) - BUF_W'(1));
        stat.trim = need < nn_reg;
        stat.push_done = NN_W'(cnt_reg) == (nn_reg - NN_W'(1));
        stat.fetch_done = f_adv && (f_t == TYPE_W'(TYPE_COUNT - 1));
        stat.out_free = out_free;
    end

    assign m_valid = out_valid_reg;
    assign m_item = out_reg;

    a_free_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg == NULL_LINK) || (free_head_reg < fresh_reg))
        else $error("free list head outside the used pool");

    a_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= LINK_W'(POOL_NODES))
        else $error("fresh count past pool size");

    a_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (nn_reg <= NN_W'(CHAIN_MAX + 1)) && (n_reg <= BUF_W'(BUF_SLOTS)))
        else $error("chain buffer overrun");

endmodule

// ----- design/chained_type_map_table.sv -----
// Per-object sorted type->handle maps held in a pool of 256 four-slot nodes.
// One word is worked at a time; s_ready is high only between words. Alloc takes
// a node from the free list or the fresh pool, dealloc reads then relinks each
// chain node, set walks the chain (link read then one slot-memory read per slot),
// then does its search/shift and writes the slots back, and fetch walks the
// chain then scans all 16 types one per cycle, stalling on a selected type
// while the output register is full. Pace is set by the slot memory and the
// chain walk; result words wait in an output register.
module chained_type_map_table import ctm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    ctm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .dcmd    (dcmd)
    );

    ctm_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .dcmd    (dcmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

// ----- tb/chained_type_map_table_tb.sv -----
module chained_type_map_table_tb;
    import ctm_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int        errors = 0;
    out_item_t map_results_q[$];
    out_item_t step_out[$];
    int        live_objs[$];

    // shadow of the node pool
    logic [4:0]  pool_types[POOL_NODES*SLOTS];
    logic [31:0] pool_values[POOL_NODES*SLOTS];
    int          pool_links[POOL_NODES];
    int          pool_fill[POOL_NODES];
    int          free_top;
    int          fresh_nodes;

    chained_type_map_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_item_t make_res(int idx, int ty, logic [31:0] va, status_t st,
                                           logic lst);
        out_item_t r;
        r.result_index = idx[7:0];
        r.result_type = ty[3:0];
        r.result_value = va;
        r.status = st;
        r.last = lst;
        return r;
    endfunction

    function automatic bit pool_can_take();
        return free_top < fresh_nodes || fresh_nodes < POOL_NODES;
    endfunction

    function automatic int pool_take();
        int node;
        if (free_top < fresh_nodes) begin
            node = free_top;
            free_top = pool_links[node];
            if (free_top >= fresh_nodes) free_top = POOL_NODES;
            return node;
        end
        node = fresh_nodes;
        fresh_nodes++;
        return node;
    endfunction

    function automatic void pool_push(int node);
        pool_links[node] = free_top;
        free_top = node;
    endfunction

    function automatic int chain_gather(int head, ref int nodes[CHAIN_MAX+1], ref int nn,
                                        ref int ty[BUF_SLOTS], ref logic [31:0] va[BUF_SLOTS]);
        int cur = head;
        int n = 0;
        int f;
        nn = 0;
        while (nn < CHAIN_MAX) begin
            f = pool_fill[cur] > SLOTS ? SLOTS : pool_fill[cur];
            nodes[nn++] = cur;
            for (int i = 0; i < f; i++) begin
                ty[n] = pool_types[cur*SLOTS+i];
                va[n] = pool_values[cur*SLOTS+i];
                n++;
            end
            if (pool_links[cur] >= fresh_nodes) break;
            cur = pool_links[cur];
        end
        return n;
    endfunction

    function automatic status_t map_set(int head, int key, logic [31:0] value);
        int nodes[CHAIN_MAX+1];
        int ty[BUF_SLOTS];
        logic [31:0] va[BUF_SLOTS];
        int nn, n, found, ins, need, nw, f;
        n = chain_gather(head, nodes, nn, ty, va);
        found = -1;
        ins = n;
        for (int i = 0; i < n; i++) begin
            if (ty[i] == key) begin found = i; break; end
            if (ty[i] > key) begin ins = i; break; end
        end
        if (value != 0) begin
            if (found >= 0) begin
                va[found] = value;
            end else begin
                need = (n + SLOTS) / SLOTS;
                if (need > nn) begin
                    if (!pool_can_take()) return ST_FULL;
                    nw = pool_take();
                    pool_links[nodes[nn-1]] = nw;
                    pool_links[nw] = POOL_NODES;
                    nodes[nn++] = nw;
                end
                for (int i = n; i > ins; i--) begin
                    ty[i] = ty[i-1];
                    va[i] = va[i-1];
                end
                ty[ins] = key;
                va[ins] = value;
                n++;
            end
        end else begin
            if (found < 0) return ST_OK;
            for (int i = found; i + 1 < n; i++) begin
                ty[i] = ty[i+1];
                va[i] = va[i+1];
            end
            n--;
        end
        need = n == 0 ? 1 : (n + SLOTS - 1) / SLOTS;
        for (int k = 0; k < need && k < nn; k++) begin
            f = n - k*SLOTS;
            if (f > SLOTS) f = SLOTS;
            if (f < 0) f = 0;
            for (int j = 0; j < f; j++) begin
                pool_types[nodes[k]*SLOTS+j] = ty[k*SLOTS+j];
                pool_values[nodes[k]*SLOTS+j] = va[k*SLOTS+j];
            end
            pool_fill[nodes[k]] = f;
        end
        if (need < nn) begin
            pool_links[nodes[need-1]] = POOL_NODES;
            for (int k = need; k < nn; k++) pool_push(nodes[k]);
        end
        return ST_OK;
    endfunction

    // fills step_out with the words one command should produce
    function automatic void map_predict(in_item_t it);
        int nodes[CHAIN_MAX+1];
        int ty[BUF_SLOTS];
        logic [31:0] va[BUF_SLOTS];
        int nn, n, idx, cur, nxt, node;
        logic [31:0] v;
        step_out.delete();
        idx = it.obj_index;
        if (it.command == CMD_ALLOC) begin
            if (!pool_can_take()) begin
                step_out.push_back(make_res(0, 0, 0, ST_FULL, 1'b1));
                return;
            end
            node = pool_take();
            pool_links[node] = POOL_NODES;
            pool_fill[node] = 0;
            live_objs.push_back(node);
            step_out.push_back(make_res(node, 0, 0, ST_OK, 1'b1));
            return;
        end
        if (idx >= fresh_nodes) begin
            step_out.push_back(make_res(0, 0, 0, ST_BAD, 1'b1));
            return;
        end
        case (it.command)
            CMD_DEALLOC: begin
                cur = idx;
                for (int c = 0; c < CHAIN_MAX; c++) begin
                    nxt = pool_links[cur];
                    pool_push(cur);
                    if (nxt >= fresh_nodes) break;
                    cur = nxt;
                end
                foreach (live_objs[i])
                    if (live_objs[i] == idx) begin
                        live_objs.delete(i);
                        break;
                    end
                step_out.push_back(make_res(0, 0, 0, ST_OK, 1'b1));
            end
            CMD_SET: begin
                step_out.push_back(make_res(0, 0, 0,
                    map_set(idx, it.entry_type, it.entry_value), 1'b1));
            end
            default: begin
                n = chain_gather(idx, nodes, nn, ty, va);
                for (int t = 0; t < TYPE_COUNT; t++) begin
                    if (!it.type_mask[t]) continue;
                    v = 0;
                    for (int i = 0; i < n; i++)
                        if (ty[i] == t) begin v = va[i]; break; end
                    step_out.push_back(make_res(0, t, v, ST_OK, 1'b0));
                end
                if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    bit tx_quiet = 1'b0;

    task automatic send_word(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        map_predict(it);
        if (typed) map_results_q.push_back(typed_res);
        else foreach (step_out[i]) map_results_q.push_back(step_out[i]);
    endtask

    function automatic in_item_t make_word(cmd_t c, int idx, int ty, logic [31:0] va,
                                           logic [15:0] mask);
        in_item_t it;
        it.command = c;
        it.obj_index = idx[7:0];
        it.entry_type = ty[3:0];
        it.entry_value = va;
        it.type_mask = mask;
        return it;
    endfunction

    // result side: random stalls, with quiet stretches
    initial begin
        int gap;
        bit quiet = 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (map_results_q.size() == 0) begin
                $error("unexpected result word %h", m_item);
                errors++;
            end else begin
                want = map_results_q.pop_front();
                if (m_item.result_index !== want.result_index) begin
                    $error("result_index exp %0d got %0d", want.result_index,
                           m_item.result_index);
                    errors++;
                end
                if (m_item.result_type !== want.result_type) begin
                    $error("result_type exp %0d got %0d", want.result_type, m_item.result_type);
                    errors++;
                end
                if (m_item.result_value !== want.result_value) begin
                    $error("result_value exp %h got %h", want.result_value,
                           m_item.result_value);
                    errors++;
                end
                if (m_item.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_item.status);
                    errors++;
                end
                if (m_item.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, m_item.last);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        in_item_t  word;
        bit        typed;
        out_item_t res;
    } dir_row_t;

    initial begin
        dir_row_t rows[$];
        int pick, idx;
        cmd_t c;
        logic [31:0] v;
        out_item_t bad_res, ok_res;

        free_top = POOL_NODES;
        fresh_nodes = 0;
        foreach (pool_links[i]) begin
            pool_links[i] = 0;
            pool_fill[i] = 0;
        end
        foreach (pool_types[i]) begin
            pool_types[i] = 0;
            pool_values[i] = 0;
        end
        bad_res = make_res(0, 0, 0, ST_BAD, 1'b1);
        ok_res = make_res(0, 0, 0, ST_OK, 1'b1);

        rows = '{
            '{make_word(CMD_FETCH, 0, 0, 0, 16'hffff), 1, bad_res},
            '{make_word(CMD_SET, 5, 3, 32'h1, 0), 1, bad_res},
            '{make_word(CMD_DEALLOC, 255, 0, 0, 0), 1, bad_res},
            '{make_word(CMD_ALLOC, 0, 0, 0, 0), 1, make_res(0, 0, 0, ST_OK, 1'b1)},
            '{make_word(CMD_ALLOC, 0, 0, 0, 0), 1, make_res(1, 0, 0, ST_OK, 1'b1)},
            '{make_word(CMD_FETCH, 0, 0, 0, 16'h0000), 0, ok_res},
            '{make_word(CMD_SET, 0, 15, 32'hffffffff, 0), 1, ok_res},
            '{make_word(CMD_SET, 0, 0, 32'h1, 0), 1, ok_res},
            '{make_word(CMD_SET, 0, 8, 32'h8888_0008, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 4, 32'h4444_0004, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 12, 32'hcccc_000c, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 7, 32'h7777_0007, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 4, 32'ha5a5a5a5, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 3, 32'h0, 0), 0, ok_res},
            '{make_word(CMD_FETCH, 0, 0, 0, 16'hffff), 0, ok_res},
            '{make_word(CMD_SET, 0, 15, 32'h0, 0), 0, ok_res},
            '{make_word(CMD_SET, 0, 12, 32'h0, 0), 0, ok_res},
            '{make_word(CMD_FETCH, 0, 0, 0, 16'h8001), 0, ok_res},
            '{make_word(CMD_DEALLOC, 0, 0, 0, 0), 1, ok_res},
            '{make_word(CMD_ALLOC, 0, 0, 0, 0), 0, ok_res},
            '{make_word(CMD_FETCH, 1, 0, 0, 16'h0001), 0, ok_res},
            '{make_word(CMD_SET, 1, 0, 32'h80000000, 0), 0, ok_res},
            '{make_word(CMD_FETCH, 1, 0, 0, 16'h5555), 0, ok_res}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) send_word(rows[r].word, rows[r].typed, rows[r].res);

        // random traffic, mostly on live objects
        for (int n = 0; n < 55; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 || live_objs.size() == 0) c = CMD_ALLOC;
            else if (pick < 25) c = CMD_DEALLOC;
            else if (pick < 75) c = CMD_SET;
            else c = CMD_FETCH;
            if (live_objs.size() > 0 && $urandom_range(0, 9) != 0)
                idx = live_objs[$urandom_range(0, live_objs.size()-1)];
            else
                idx = $urandom_range(0, 255);
            v = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
            send_word(make_word(c, idx, $urandom_range(0, 15), v, $urandom_range(0, 16'hffff)));
        end

        // fill one object with every type, then churn the free list
        if (live_objs.size() > 0) begin
            idx = live_objs[0];
            for (int t = 0; t < TYPE_COUNT; t++)
                send_word(make_word(CMD_SET, idx, t, $urandom | 32'h1, 0));
            send_word(make_word(CMD_FETCH, idx, 0, 0, 16'hffff));
        end
        repeat (8) begin
            if (live_objs.size() > 0)
                send_word(make_word(CMD_DEALLOC, live_objs[live_objs.size()-1], 0, 0, 0));
            send_word(make_word(CMD_ALLOC, 0, 0, 0, 0));
        end
        s_valid <= 1'b0;

        while (map_results_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS chained_type_map_table");
        end else begin
            $display("FAIL chained_type_map_table");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAIL chained_type_map_table");
        $finish;
    end

endmodule
